@@ src/qts_pkg.sv @@
// Shared types and character constants for the quoted token splitter.
package qts_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_SKIP   = 2'd1,
    MODE_QUOTED = 2'd2,
    MODE_PLAIN  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       char_valid;
    logic       token_end;
    logic       last_of_run;
  } res_t;

endpackage

@@ src/qts_in_if.sv @@
// Input channel: one string character per request.
interface qts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, in_byte, end_of_string, input ready);
  modport sink (input valid, in_byte, end_of_string, output ready);
endinterface

@@ src/qts_out_if.sv @@
// Output channel: one token result per request.
interface qts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       token_end;
  logic       last_of_run;

  modport source (output valid, out_char, char_valid, token_end, last_of_run, input ready);
  modport sink (input valid, out_char, char_valid, token_end, last_of_run, output ready);
endinterface

@@ src/qts_step.sv @@
// Per-character tokenizer step: next mode, escape flag and up to two results.
module qts_step (
  input  qts_pkg::mode_t mode,
  input  logic           esc,
  input  logic [7:0]     ch,
  input  logic           eos,
  output qts_pkg::mode_t mode_next,
  output logic           esc_next,
  output qts_pkg::res_t  res0,
  output qts_pkg::res_t  res1,
  output logic [1:0]     res_n
);
  import qts_pkg::*;

  logic is_bs;
  logic is_sp;
  logic is_q;
  logic is_bang;

  assign is_bs   = (ch == CH_BSLASH);
  assign is_sp   = (ch == CH_SPACE);
  assign is_q    = (ch == CH_QUOTE);
  assign is_bang = (ch == CH_BANG);

  always_comb begin
    res_t       r [2];
    logic [1:0] n;
    mode_t      m;
    logic       e;
    logic       do_plain;
    logic       pe;
    logic [0:0] li;

    r[0]     = '0;
    r[1]     = '0;
    n        = 2'd0;
    m        = mode;
    e        = esc;
    do_plain = 1'b0;
    pe       = 1'b0;
    li       = 1'b0;

    unique case (mode) inside
      MODE_START, MODE_SKIP: begin
        if (!(mode == MODE_SKIP && is_sp)) begin
          e = 1'b0;
          if (is_q) begin
            m = MODE_QUOTED;
          end else if (is_bang) begin
            r[n[0]] = '{ch: CH_BANG, char_valid: 1'b1, token_end: 1'b1, last_of_run: 1'b0};
            n = n + 2'd1;
            m = MODE_SKIP;
          end else begin
            m        = MODE_PLAIN;
            do_plain = 1'b1;
            pe       = 1'b0;
          end
        end
      end
      MODE_QUOTED: begin
        if (is_bs && !esc) begin
          e = 1'b1;
        end else if (is_bs || (is_q && esc)) begin
          r[n[0]] = '{ch: ch, char_valid: 1'b1, token_end: 1'b0, last_of_run: 1'b0};
          n = n + 2'd1;
          e = 1'b0;
        end else if (is_q) begin
          r[n[0]] = '{ch: 8'd0, char_valid: 1'b0, token_end: 1'b1, last_of_run: 1'b0};
          n = n + 2'd1;
          m = MODE_SKIP;
        end else begin
          if (esc) begin
            r[n[0]] = '{ch: CH_BSLASH, char_valid: 1'b1, token_end: 1'b0, last_of_run: 1'b0};
            n = n + 2'd1;
          end
          r[n[0]] = '{ch: ch, char_valid: 1'b1, token_end: 1'b0, last_of_run: 1'b0};
          n = n + 2'd1;
          e = 1'b0;
        end
      end
      MODE_PLAIN: begin
        do_plain = 1'b1;
        pe       = esc;
      end
      default: begin
        m = MODE_START;
      end
    endcase

    if (do_plain) begin
      if (is_bs) begin
        e = 1'b1;
      end else if (is_sp && pe) begin
        r[n[0]] = '{ch: CH_SPACE, char_valid: 1'b1, token_end: 1'b0, last_of_run: 1'b0};
        n = n + 2'd1;
        e = 1'b0;
      end else if (is_sp) begin
        r[n[0]] = '{ch: 8'd0, char_valid: 1'b0, token_end: 1'b1, last_of_run: 1'b0};
        n = n + 2'd1;
        e = 1'b0;
        m = MODE_SKIP;
      end else begin
        if (pe) begin
          r[n[0]] = '{ch: CH_BSLASH, char_valid: 1'b1, token_end: 1'b0, last_of_run: 1'b0};
          n = n + 2'd1;
        end
        r[n[0]] = '{ch: ch, char_valid: 1'b1, token_end: 1'b0, last_of_run: 1'b0};
        n = n + 2'd1;
        e = 1'b0;
      end
    end

    if (eos) begin
      if (m == MODE_QUOTED || m == MODE_PLAIN) begin
        if (n != 2'd0) begin
          li = 1'(n - 2'd1);
          r[li].token_end = 1'b1;
        end else begin
          r[0] = '{ch: 8'd0, char_valid: 1'b0, token_end: 1'b1, last_of_run: 1'b0};
          n = 2'd1;
        end
      end
      m = MODE_START;
      e = 1'b0;
    end

    if (n != 2'd0) begin
      li = 1'(n - 2'd1);
      r[li].last_of_run = 1'b1;
    end

    res0      = r[0];
    res1      = r[1];
    res_n     = n;
    mode_next = m;
    esc_next  = e;
  end

endmodule

@@ src/qts_res_queue.sv @@
// Result queue: takes up to two results per cycle, hands out one per request.
module qts_res_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [1:0]    push_n,
  input  qts_pkg::res_t res0,
  input  qts_pkg::res_t res1,
  output logic          fits,
  qts_out_if.source     out_stream
);
  import qts_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          q [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic [CW:0]   need;
  logic          pop;
  logic [1:0]    push_amt;
  logic [PW-1:0] tail1;
  res_t          hd;

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign need     = (CW + 1)'(cnt) + (CW + 1)'(push_n);
  assign fits     = (need <= (CW + 1)'(DEPTH));
  assign pop      = out_stream.valid && out_stream.ready;
  assign push_amt = push ? push_n : 2'd0;
  assign tail1    = nxt(tail);
  assign cnt_next = cnt + CW'(push_amt) - CW'(pop);

  assign hd                     = q[head];
  assign out_stream.valid       = (cnt != '0);
  assign out_stream.out_char    = hd.ch;
  assign out_stream.char_valid  = hd.char_valid;
  assign out_stream.token_end   = hd.token_end;
  assign out_stream.last_of_run = hd.last_of_run;

  always_ff @(posedge clk) begin
    if (push_amt != 2'd0) begin
      q[tail] <= res0;
    end
    if (push_amt == 2'd2) begin
      q[tail1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      cnt  <= '0;
    end else begin
      cnt <= cnt_next;
      if (pop) begin
        head <= nxt(head);
      end
      if (push_amt == 2'd1) begin
        tail <= tail1;
      end else if (push_amt == 2'd2) begin
        tail <= nxt(tail1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("result queue over depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> fits)
    else $error("push without room");

endmodule

@@ src/quoted_token_splitter.sv @@
// Top level of the quoted token splitter.
//
// Usage: in_stream carries one string character per request with
// end_of_string set on the final character. out_stream carries the token
// results: out_char with char_valid, token_end on the last result of a
// token, and last_of_run on the last result caused by one character.
// A character may give zero, one or two results.
//
// A character is held in the input register; its results are then written
// into the result queue, which presents them on out_stream. Throughput:
// one character per cycle while the queue has room for its results; a
// character giving two results uses the single-result output port twice,
// so the output port of the QUEUE_DEPTH-entry result queue sets the rate.
//
// Reset (rst, synchronous): empties the input register and the result
// queue and returns the tokenizer to the token start with no escape pending.
// When the receiver stalls, results collect in the queue; once it cannot
// take the results of the registered character, in_stream.ready drops.
module quoted_token_splitter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  qts_in_if.sink    in_stream,
  qts_out_if.source out_stream
);
  import qts_pkg::*;

  logic       in_v;
  logic [7:0] in_b;
  logic       in_eos;
  mode_t      mode;
  mode_t      mode_next;
  logic       esc;
  logic       esc_next;
  res_t       res0;
  res_t       res1;
  logic [1:0] res_n;
  logic       fits;
  logic       adv;

  assign adv             = in_v && fits;
  assign in_stream.ready = !in_v || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_stream.ready) begin
      in_v <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.valid && in_stream.ready) begin
      in_b   <= in_stream.in_byte;
      in_eos <= in_stream.end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_START;
      esc  <= 1'b0;
    end else if (adv) begin
      mode <= mode_next;
      esc  <= esc_next;
    end
  end

  qts_step u_step (
    .mode      (mode),
    .esc       (esc),
    .ch        (in_b),
    .eos       (in_eos),
    .mode_next (mode_next),
    .esc_next  (esc_next),
    .res0      (res0),
    .res1      (res1),
    .res_n     (res_n)
  );

  qts_res_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (adv),
    .push_n     (res_n),
    .res0       (res0),
    .res1       (res1),
    .fits       (fits),
    .out_stream (out_stream)
  );

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (in_v && !adv) |=> (in_v && $stable(in_b) && $stable(in_eos)))
    else $error("stalled character lost");

  a_eos_restart: assert property (@(posedge clk) disable iff (rst)
    (adv && in_eos) |=> (mode == MODE_START && !esc))
    else $error("string end did not restart tokenizer");

  a_esc_in_token: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_START || mode == MODE_SKIP) |-> !esc)
    else $error("escape pending outside a token");

endmodule

@@ tb/tb_quoted_token_splitter.sv @@
// Self-checking testbench for the quoted token splitter: directed table, then random strings.
module tb_quoted_token_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  import qts_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       eos;
    int         n_typed;
    res_t       r0;
    res_t       r1;
  } row_t;

  localparam int ITEM_GOAL = 1100;

  logic clk;
  logic rst;

  qts_in_if  in_ch ();
  qts_out_if out_ch ();

  quoted_token_splitter dut (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_ch),
    .out_stream (out_ch)
  );

  mode_t      tok_mode;
  logic       esc_pend;
  res_t       step_q[$];
  res_t       token_q[$];
  int         errors;
  int         printed;
  int         items_sent;
  int         cur_typed;
  res_t       cur_r0;
  res_t       cur_r1;
  logic [7:0] str_q[$];
  int         rx_max;

  row_t dir_rows[25] = '{
    '{8'h21, 1'b0, 1, '{8'h21, 1'b1, 1'b1, 1'b1}, '0},
    '{8'h20, 1'b0, 0, '0, '0},
    '{8'h22, 1'b0, -1, '0, '0},
    '{8'h22, 1'b0, 1, '{8'h00, 1'b0, 1'b1, 1'b1}, '0},
    '{8'h20, 1'b0, -1, '0, '0},
    '{8'h61, 1'b0, -1, '0, '0},
    '{8'h5C, 1'b0, -1, '0, '0},
    '{8'h5C, 1'b0, -1, '0, '0},
    '{8'h78, 1'b0, -1, '0, '0},
    '{8'h5C, 1'b0, -1, '0, '0},
    '{8'h20, 1'b0, -1, '0, '0},
    '{8'h22, 1'b0, -1, '0, '0},
    '{8'h21, 1'b0, -1, '0, '0},
    '{8'h20, 1'b0, -1, '0, '0},
    '{8'h22, 1'b0, -1, '0, '0},
    '{8'h5C, 1'b0, -1, '0, '0},
    '{8'h22, 1'b0, -1, '0, '0},
    '{8'h5C, 1'b0, -1, '0, '0},
    '{8'h5C, 1'b0, -1, '0, '0},
    '{8'h5C, 1'b0, -1, '0, '0},
    '{8'hFF, 1'b0, 2, '{8'h5C, 1'b1, 1'b0, 1'b0}, '{8'hFF, 1'b1, 1'b0, 1'b1}},
    '{8'h00, 1'b1, 1, '{8'h00, 1'b1, 1'b1, 1'b1}, '0},
    '{8'h20, 1'b0, 1, '{8'h00, 1'b0, 1'b1, 1'b1}, '0},
    '{8'h5C, 1'b1, -1, '0, '0},
    '{8'h20, 1'b1, -1, '0, '0}
  };

  function automatic void add_res(input logic [7:0] ch, input logic v, input logic e);
    res_t r;
    r.ch          = ch;
    r.char_valid  = v;
    r.token_end   = e;
    r.last_of_run = 1'b0;
    step_q = {step_q, r};
  endfunction

  function automatic void plain_step(input logic [7:0] c);
    if (c == CH_BSLASH) begin
      esc_pend = 1'b1;
    end else if (c == CH_SPACE && esc_pend) begin
      add_res(CH_SPACE, 1'b1, 1'b0);
      esc_pend = 1'b0;
    end else if (c == CH_SPACE) begin
      add_res(8'h00, 1'b0, 1'b1);
      esc_pend = 1'b0;
      tok_mode = MODE_SKIP;
    end else begin
      if (esc_pend) add_res(CH_BSLASH, 1'b1, 1'b0);
      add_res(c, 1'b1, 1'b0);
      esc_pend = 1'b0;
    end
  endfunction

  function automatic void quoted_step(input logic [7:0] c);
    if (c == CH_BSLASH && !esc_pend) begin
      esc_pend = 1'b1;
    end else if (c == CH_BSLASH || (c == CH_QUOTE && esc_pend)) begin
      add_res(c, 1'b1, 1'b0);
      esc_pend = 1'b0;
    end else if (c == CH_QUOTE) begin
      add_res(8'h00, 1'b0, 1'b1);
      tok_mode = MODE_SKIP;
    end else begin
      if (esc_pend) add_res(CH_BSLASH, 1'b1, 1'b0);
      add_res(c, 1'b1, 1'b0);
      esc_pend = 1'b0;
    end
  endfunction

  function automatic void start_step(input logic [7:0] c);
    esc_pend = 1'b0;
    if (c == CH_QUOTE) begin
      tok_mode = MODE_QUOTED;
    end else if (c == CH_BANG) begin
      add_res(CH_BANG, 1'b1, 1'b1);
      tok_mode = MODE_SKIP;
    end else begin
      tok_mode = MODE_PLAIN;
      plain_step(c);
    end
  endfunction

  function automatic void split_char(input logic [7:0] c, input logic eos);
    step_q.delete();
    case (tok_mode)
      MODE_START: start_step(c);
      MODE_SKIP: begin
        if (c != CH_SPACE) start_step(c);
      end
      MODE_QUOTED: quoted_step(c);
      default: plain_step(c);
    endcase
    if (eos) begin
      if (tok_mode == MODE_QUOTED || tok_mode == MODE_PLAIN) begin
        if (step_q.size() > 0) step_q[$].token_end = 1'b1;
        else add_res(8'h00, 1'b0, 1'b1);
      end
      tok_mode = MODE_START;
      esc_pend = 1'b0;
    end
    if (step_q.size() > 0) step_q[$].last_of_run = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input res_t got, input res_t want);
    errors++;
    if (printed < 100) begin
      printed++;
      $display("%0t mismatch (%s): got ch=%h v=%b e=%b l=%b, want ch=%h v=%b e=%b l=%b",
               $realtime, what, got.ch, got.char_valid, got.token_end, got.last_of_run,
               want.ch, want.char_valid, want.token_end, want.last_of_run);
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        split_char(in_ch.in_byte, in_ch.end_of_string);
        if (cur_typed >= 0) begin
          if (cur_typed > 0) token_q = {token_q, cur_r0};
          if (cur_typed > 1) token_q = {token_q, cur_r1};
        end else begin
          foreach (step_q[i]) token_q = {token_q, step_q[i]};
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_char, out_ch.char_valid, out_ch.token_end, out_ch.last_of_run};
        if (token_q.size() == 0) begin
          report_mismatch("unexpected result", got, '0);
        end else begin
          want = token_q.pop_front();
          if (got.ch != want.ch || got.char_valid != want.char_valid ||
              got.token_end != want.token_end || got.last_of_run != want.last_of_run)
            report_mismatch("field", got, want);
        end
      end
    end
  end

  task automatic send_char(input logic [7:0] b, input logic eos, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= b;
    in_ch.end_of_string <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (token_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int w;
    w = $urandom_range(0, 9);
    case (w)
      0, 1: return CH_BSLASH;
      2: return CH_QUOTE;
      3: return CH_SPACE;
      4: return CH_BANG;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void build_string();
    int n_tok;
    int len;
    int kind;
    logic [7:0] c;
    str_q.delete();
    if ($urandom_range(0, 7) == 0) begin
      len = $urandom_range(1, 8);
      repeat (len) str_q = {str_q, 8'($urandom_range(0, 255))};
      return;
    end
    if ($urandom_range(0, 7) == 0) str_q = {str_q, CH_SPACE};
    n_tok = $urandom_range(1, 4);
    for (int t = 0; t < n_tok; t++) begin
      if (t > 0) repeat ($urandom_range(1, 3)) str_q = {str_q, CH_SPACE};
      kind = $urandom_range(0, 2);
      len  = $urandom_range(0, 6);
      if (kind == 0) begin
        str_q = {str_q, CH_BANG};
      end else if (kind == 1) begin
        str_q = {str_q, CH_QUOTE};
        repeat (len) begin
          c = pick_char();
          if (c == CH_QUOTE && $urandom_range(0, 3) != 0) str_q = {str_q, CH_BSLASH};
          str_q = {str_q, c};
        end
        if (t != n_tok - 1 || $urandom_range(0, 5) != 0) str_q = {str_q, CH_QUOTE};
      end else begin
        str_q = {str_q, 8'($urandom_range(8'h61, 8'h7A))};
        repeat (len) begin
          c = pick_char();
          if (c == CH_SPACE && $urandom_range(0, 3) != 0) str_q = {str_q, CH_BSLASH};
          str_q = {str_q, c};
        end
      end
    end
    if ($urandom_range(0, 5) == 0) str_q = {str_q, CH_SPACE};
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int stall;
    rx_max = 19;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      for (int k = 0; k < 30; k++) begin
        stall = (rx_max == 0) ? 0 : $urandom_range(0, rx_max);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
        while (!out_ch.valid) @(posedge clk);
        @(negedge clk);
      end
      rx_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
    end
  end

  initial begin
    int gap_max;
    int n_str;
    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.in_byte       = 8'h00;
    in_ch.end_of_string = 1'b0;
    tok_mode            = MODE_START;
    esc_pend            = 1'b0;
    errors              = 0;
    printed             = 0;
    items_sent          = 0;
    cur_typed           = -1;
    cur_r0              = '0;
    cur_r1              = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      cur_typed = dir_rows[i].n_typed;
      cur_r0    = dir_rows[i].r0;
      cur_r1    = dir_rows[i].r1;
      send_char(dir_rows[i].b, dir_rows[i].eos, $urandom_range(0, 19));
    end
    cur_typed = -1;
    drain_results();

    n_str = 0;
    while (items_sent < ITEM_GOAL) begin
      build_string();
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
      foreach (str_q[i]) begin
        send_char(str_q[i], (i == str_q.size() - 1) ? 1'b1 : ($urandom_range(0, 49) == 0),
                  $urandom_range(0, gap_max));
      end
      n_str++;
      if (n_str % 10 == 0) drain_results();
    end
    in_ch.valid <= 1'b0;

    while (token_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && token_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
